/* src/fbfill_pkg.sv */
// Shared package of the clipped rectangle fill framebuffer.
// Holds panel geometry, derived widths, the queued command type, the back-end
// state type and the pixel address function. Used by every module of the block but fbfill_ram.
package fbfill_pkg;

  localparam int PANEL_WIDTH  = 64;
  localparam int PANEL_HEIGHT = 32;
  localparam int PIXELS       = PANEL_WIDTH * PANEL_HEIGHT;

  localparam int COL_W  = (PANEL_WIDTH > 1) ? $clog2(PANEL_WIDTH) : 1;
  localparam int ROW_W  = (PANEL_HEIGHT > 1) ? $clog2(PANEL_HEIGHT) : 1;
  localparam int ADDR_W = (PIXELS > 1) ? $clog2(PIXELS) : 1;

  localparam int COORD_W = 16;
  localparam int COLOR_W = 16;
  localparam int IN_DATA_W = 4 * COORD_W + COLOR_W;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);

  localparam logic OP_FILL = 1'b0;
  localparam logic OP_READ = 1'b1;

  // One classified command as it waits between front and back.
  typedef struct packed {
    logic               is_read;
    logic               active;     // fill touches the panel, or read is on the panel
    logic [COL_W-1:0]   col_first;
    logic [COL_W-1:0]   col_last;
    logic [ROW_W-1:0]   row_first;
    logic [ROW_W-1:0]   row_last;
    logic [COLOR_W-1:0] color;
  } fb_cmd_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_FILL,
    BK_READ
  } back_state_t;

  // Pixels are stored row by row.
  function automatic logic [ADDR_W-1:0] pix_addr(input logic [ROW_W-1:0] row,
                                                 input logic [COL_W-1:0] col);
    logic [ADDR_W-1:0] base;
    base = ADDR_W'(row) * ADDR_W'(PANEL_WIDTH);
    return base + ADDR_W'(col);
  endfunction

endpackage

/* src/fbfill_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No package dependency; width and depth come from its parameters.
module fbfill_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/fbfill_front.sv */
// Front end: takes input beats and clips each command against the panel.
// Depends on fbfill_pkg; its output feeds the command queue.
module fbfill_front (
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [fbfill_pkg::IN_DATA_W-1:0]     s_tdata,
  input  logic                                 s_tuser,
  input  logic                                 queue_full,
  input  logic                                 clear_done,
  output logic                                 push,
  output fbfill_pkg::fb_cmd_t                  cmd
);
  import fbfill_pkg::*;

  localparam logic signed [COORD_W:0] W_EXT = (COORD_W + 1)'(PANEL_WIDTH);
  localparam logic signed [COORD_W:0] H_EXT = (COORD_W + 1)'(PANEL_HEIGHT);
  localparam logic signed [COORD_W:0] ONE_EXT = (COORD_W + 1)'(1);

  logic signed [COORD_W-1:0] x_pos, y_pos, rect_width, rect_height;
  logic signed [COORD_W:0]   x_ext, y_ext, x_end, y_end;
  logic                      col_hit, row_hit, x_on, y_on;

  assign x_pos       = s_tdata[COORD_W-1:0];
  assign y_pos       = s_tdata[2*COORD_W-1:COORD_W];
  assign rect_width  = s_tdata[3*COORD_W-1:2*COORD_W];
  assign rect_height = s_tdata[4*COORD_W-1:3*COORD_W];

  assign x_ext = {x_pos[COORD_W-1], x_pos};
  assign y_ext = {y_pos[COORD_W-1], y_pos};
  // One past the last column and row, at full width so nothing wraps.
  assign x_end = x_ext + {rect_width[COORD_W-1], rect_width};
  assign y_end = y_ext + {rect_height[COORD_W-1], rect_height};

  assign x_on = (x_ext >= 0) && (x_ext < W_EXT);
  assign y_on = (y_ext >= 0) && (y_ext < H_EXT);

  assign col_hit = (rect_width > 0) && (x_ext < W_EXT) && (x_end > 0);
  assign row_hit = (rect_height > 0) && (y_ext < H_EXT) && (y_end > 0);

  assign s_tready = !queue_full && clear_done;
  assign push     = s_tvalid && s_tready;

  always_comb begin
    cmd.is_read   = (s_tuser == OP_READ);
    cmd.active    = cmd.is_read ? (x_on && y_on) : (col_hit && row_hit);
    cmd.col_first = (x_ext < 0) ? '0 : x_pos[COL_W-1:0];
    cmd.row_first = (y_ext < 0) ? '0 : y_pos[ROW_W-1:0];
    cmd.col_last  = (x_end >= W_EXT) ? COL_W'(PANEL_WIDTH - 1)
                                     : COL_W'(x_end - ONE_EXT);
    cmd.row_last  = (y_end >= H_EXT) ? ROW_W'(PANEL_HEIGHT - 1)
                                     : ROW_W'(y_end - ONE_EXT);
    cmd.color     = s_tdata[IN_DATA_W-1:4*COORD_W];
  end

endmodule

/* src/fbfill_queue.sv */
// Short command queue between the front end and the back end.
// Depends on fbfill_pkg for the command type and its depth.
module fbfill_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  fbfill_pkg::fb_cmd_t push_cmd,
  input  logic                pop,
  output logic                full,
  output logic                not_empty,
  output fbfill_pkg::fb_cmd_t head
);
  import fbfill_pkg::*;

  fb_cmd_t            entry [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr, rd_ptr;
  logic [QCNT_W-1:0]  count;

  assign full      = (count == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_cmd;
    end
  end

endmodule

/* src/fbfill_back.sv */
// Back end: clears the pixel memory after reset, then runs queued commands,
// one pixel write per cycle for fills, and holds each result in an output register.
// Depends on fbfill_pkg and fbfill_ram.
module fbfill_back (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cmd_valid,
  input  fbfill_pkg::fb_cmd_t                 cmd,
  output logic                                pop,
  output logic                                clear_done,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [fbfill_pkg::COLOR_W-1:0]      m_tdata,
  output logic                                m_tuser
);
  import fbfill_pkg::*;

  back_state_t        state, state_next;
  logic [ADDR_W-1:0]  clr_addr;
  logic [COL_W-1:0]   col, col_first, col_last;
  logic [ROW_W-1:0]   row, row_last;
  logic [COLOR_W-1:0] color;

  logic               res_valid;
  logic [COLOR_W-1:0] res_color;
  logic               res_is_read;

  logic               ram_we, ram_re;
  logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [COLOR_W-1:0] ram_wdata, ram_rdata;

  logic               res_load, res_load_read;
  logic [COLOR_W-1:0] res_color_next;
  logic               fill_load, col_wrap, fill_end, clr_end;

  assign clr_end  = (clr_addr == ADDR_W'(PIXELS - 1));
  assign col_wrap = (col == col_last);
  assign fill_end = col_wrap && (row == row_last);

  fbfill_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (PIXELS)
  ) u_pixels (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      BK_CLEAR: begin
        if (clr_end) begin
          state_next = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (cmd_valid && !res_valid && cmd.active) begin
          state_next = cmd.is_read ? BK_READ : BK_FILL;
        end
      end
      BK_FILL: begin
        if (fill_end) begin
          state_next = BK_IDLE;
        end
      end
      BK_READ: begin
        state_next = BK_IDLE;
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  // Outputs of each state.
  always_comb begin
    pop            = 1'b0;
    fill_load      = 1'b0;
    res_load       = 1'b0;
    res_load_read  = 1'b0;
    res_color_next = '0;
    ram_we         = 1'b0;
    ram_waddr      = pix_addr(row, col);
    ram_wdata      = color;
    ram_re         = 1'b0;
    ram_raddr      = pix_addr(cmd.row_first, cmd.col_first);
    unique case (state)
      BK_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
      end
      BK_IDLE: begin
        // A command starts only while the result register is empty.
        if (cmd_valid && !res_valid) begin
          pop = 1'b1;
          if (cmd.is_read && cmd.active) begin
            ram_re = 1'b1;
          end else if (!cmd.is_read && cmd.active) begin
            fill_load = 1'b1;
          end else begin
            res_load      = 1'b1;
            res_load_read = cmd.is_read;
          end
        end
      end
      BK_FILL: begin
        ram_we = 1'b1;
        if (fill_end) begin
          res_load = 1'b1;
        end
      end
      BK_READ: begin
        res_load       = 1'b1;
        res_load_read  = 1'b1;
        res_color_next = ram_rdata;
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_CLEAR;
      clr_addr  <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == BK_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (m_tready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fill_load) begin
      col       <= cmd.col_first;
      col_first <= cmd.col_first;
      col_last  <= cmd.col_last;
      row       <= cmd.row_first;
      row_last  <= cmd.row_last;
      color     <= cmd.color;
    end else if (state == BK_FILL) begin
      if (col_wrap) begin
        col <= col_first;
        row <= row + 1'b1;
      end else begin
        col <= col + 1'b1;
      end
    end
    if (res_load) begin
      res_color   <= res_color_next;
      res_is_read <= res_load_read;
    end
  end

  assign clear_done = (state != BK_CLEAR);
  assign m_tvalid   = res_valid;
  assign m_tdata    = res_color;
  assign m_tuser    = res_is_read;

endmodule

/* src/framebuffer_clipped_rect_fill.sv */
// Top level of the clipped rectangle fill framebuffer.
// Depends on fbfill_pkg, fbfill_front, fbfill_queue and fbfill_back.
//
// Input channel s_*: one beat is one command. s_tuser is the op (0 fill a
// rectangle, 1 read one pixel); s_tdata holds x_pos, y_pos, rect_width,
// rect_height and fill_color, 16 bits each from the lowest bit up.
// Output channel m_*: exactly one beat per command, in command order.
// m_tdata is read_color, m_tuser is is_read. Fills answer with zero color.
//
// After reset the 2048-entry pixel memory is cleared one entry per cycle,
// so s_tready stays low until the clear is done. Commands then pass through a
// two-entry queue to the back end, which runs them one at a time.
// In the back end a fill writes each pixel of its clipped area in turn,
// a read uses a registered memory read, and a fill or read that misses the
// panel loads the result register straight from idle. The next command
// starts only once the result register has been emptied.
// When m_tready is low the result register holds its beat, the back end
// waits, and the queue keeps taking commands until it is full.
module framebuffer_clipped_rect_fill (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // x_pos, y_pos, rect_width, rect_height, fill_color
  input  logic [fbfill_pkg::IN_DATA_W-1:0]   s_tdata,
  // op
  input  logic                               s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // read_color
  output logic [fbfill_pkg::COLOR_W-1:0]     m_tdata,
  // is_read
  output logic                               m_tuser
);
  import fbfill_pkg::*;

  fb_cmd_t front_cmd, head_cmd;
  logic    push, pop, queue_full, queue_valid, clear_done;

  fbfill_front u_front (
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .queue_full (queue_full),
    .clear_done (clear_done),
    .push       (push),
    .cmd        (front_cmd)
  );

  fbfill_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (front_cmd),
    .pop       (pop),
    .full      (queue_full),
    .not_empty (queue_valid),
    .head      (head_cmd)
  );

  fbfill_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (queue_valid),
    .cmd        (head_cmd),
    .pop        (pop),
    .clear_done (clear_done),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser)
  );

endmodule

/* sim/tb_top.sv */
// Testbench for framebuffer_clipped_rect_fill: directed and random fill and read
// commands, checked beat by beat against a behavioral framebuffer kept in the bench.
// Depends on fbfill_pkg and the framebuffer_clipped_rect_fill top level.
module tb_top;
  import fbfill_pkg::*;

  typedef struct {
    logic               op;
    logic signed [15:0] x_pos;
    logic signed [15:0] y_pos;
    logic signed [15:0] rect_width;
    logic signed [15:0] rect_height;
    logic [15:0]        fill_color;
  } fb_command_t;

  typedef struct {
    logic [15:0] read_color;
    logic        is_read;
  } fb_answer_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [IN_DATA_W-1:0] s_tdata = '0;
  logic                 s_tuser = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [COLOR_W-1:0]   m_tdata;
  logic                 m_tuser;

  logic [15:0] panel_pixels [PIXELS];
  fb_answer_t  pending_answers [$];
  int          mismatch_count = 0;
  int          sender_idle_pct = 0;
  int          receiver_stall_pct = 0;

  framebuffer_clipped_rect_fill dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(negedge clk) begin
    m_tready <= (int'($urandom_range(99)) >= receiver_stall_pct);
  end

  task automatic flag_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  // Applies one command to the bench copy of the panel and returns its answer.
  // Sums are taken in 32 bits so origin plus extent never wraps.
  function automatic fb_answer_t paint_or_sample(input fb_command_t cmd);
    fb_answer_t ans;
    int x0, x1, y0, y1, row, col, xs, ys;
    ans.read_color = '0;
    ans.is_read    = 1'b0;
    xs = int'(cmd.x_pos);
    ys = int'(cmd.y_pos);
    if (cmd.op == OP_READ) begin
      ans.is_read = 1'b1;
      if (xs >= 0 && xs < PANEL_WIDTH && ys >= 0 && ys < PANEL_HEIGHT)
        ans.read_color = panel_pixels[ys * PANEL_WIDTH + xs];
    end else if (cmd.rect_width > 0 && cmd.rect_height > 0) begin
      x0 = (xs < 0) ? 0 : xs;
      y0 = (ys < 0) ? 0 : ys;
      x1 = xs + int'(cmd.rect_width);
      y1 = ys + int'(cmd.rect_height);
      if (x1 > PANEL_WIDTH) x1 = PANEL_WIDTH;
      if (y1 > PANEL_HEIGHT) y1 = PANEL_HEIGHT;
      for (row = y0; row < y1; row++)
        for (col = x0; col < x1; col++)
          panel_pixels[row * PANEL_WIDTH + col] = cmd.fill_color;
    end
    return ans;
  endfunction

  function automatic fb_command_t make_cmd(input logic op, input int x, input int y,
                                           input int w, input int h, input int color);
    fb_command_t cmd;
    cmd.op          = op;
    cmd.x_pos       = 16'(x);
    cmd.y_pos       = 16'(y);
    cmd.rect_width  = 16'(w);
    cmd.rect_height = 16'(h);
    cmd.fill_color  = 16'(color);
    return cmd;
  endfunction

  // Drives one command beat and records its answer once the beat is taken.
  task automatic send_cmd(input fb_command_t cmd);
    @(negedge clk);
    while (int'($urandom_range(99)) < sender_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd.op;
    s_tdata  <= {cmd.fill_color, cmd.rect_height, cmd.rect_width, cmd.y_pos, cmd.x_pos};
    do @(posedge clk); while (!s_tready);
    pending_answers.push_back(paint_or_sample(cmd));
  endtask

  // Stops sending and waits until every answer is back, plus a short margin.
  task automatic wait_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  always @(posedge clk) begin
    fb_answer_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_answers.size() == 0) begin
        flag_mismatch($sformatf("unexpected beat color=%h is_read=%b", m_tdata, m_tuser));
      end else begin
        want = pending_answers.pop_front();
        if (m_tdata !== want.read_color)
          flag_mismatch($sformatf("read_color %h, expected %h", m_tdata, want.read_color));
        if (m_tuser !== want.is_read)
          flag_mismatch($sformatf("is_read %b, expected %b", m_tuser, want.is_read));
      end
    end
  end

  task automatic test_cleared_panel();
    send_cmd(make_cmd(OP_READ, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(OP_READ, PANEL_WIDTH - 1, PANEL_HEIGHT - 1, 0, 0, 0));
  endtask

  task automatic test_fill_shapes();
    // Full screen, then a single pixel, a horizontal line and a vertical line.
    send_cmd(make_cmd(OP_FILL, -5, -5, 100, 100, 16'hA5A5));
    send_cmd(make_cmd(OP_READ, 20, 20, 0, 0, 0));
    send_cmd(make_cmd(OP_FILL, 10, 5, 1, 1, 16'h1234));
    send_cmd(make_cmd(OP_READ, 10, 5, 0, 0, 0));
    send_cmd(make_cmd(OP_READ, 11, 5, 0, 0, 0));
    send_cmd(make_cmd(OP_FILL, 0, 7, PANEL_WIDTH, 1, 16'h0F0F));
    send_cmd(make_cmd(OP_READ, 33, 7, 0, 0, 0));
    send_cmd(make_cmd(OP_FILL, PANEL_WIDTH - 1, 0, 1, PANEL_HEIGHT, 16'hF0F0));
    send_cmd(make_cmd(OP_READ, PANEL_WIDTH - 1, PANEL_HEIGHT - 1, 0, 0, 0));
  endtask

  task automatic test_empty_and_offpanel_fills();
    send_cmd(make_cmd(OP_FILL, 12, 12, 0, 5, 16'h7777));
    send_cmd(make_cmd(OP_FILL, 12, 12, 3, -1, 16'h7777));
    send_cmd(make_cmd(OP_FILL, -32768, -32768, -32768, -32768, 16'hFFFF));
    send_cmd(make_cmd(OP_FILL, 32767, 32767, 32767, 32767, 16'hFFFF));
    // Ends exactly at column and row zero, so it stays off the panel.
    send_cmd(make_cmd(OP_FILL, -10, -10, 10, 10, 16'h5555));
    send_cmd(make_cmd(OP_READ, 12, 12, 0, 0, 0));
  endtask

  task automatic test_clipping();
    send_cmd(make_cmd(OP_FILL, 60, 28, 10, 10, 16'h0000));
    send_cmd(make_cmd(OP_FILL, -3, -2, 5, 4, 16'h8001));
    send_cmd(make_cmd(OP_READ, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(OP_READ, 1, 1, 0, 0, 0));
  endtask

  task automatic test_offpanel_reads();
    send_cmd(make_cmd(OP_READ, -1, 0, -1, -1, 16'hFFFF));
    send_cmd(make_cmd(OP_READ, PANEL_WIDTH, 0, 0, 0, 0));
    send_cmd(make_cmd(OP_READ, 0, PANEL_HEIGHT, 0, 0, 0));
    send_cmd(make_cmd(OP_READ, -32768, 32767, 32767, -32768, 16'h0001));
  endtask

  // Mostly small rectangles and reads near the panel, with some fields now
  // and then drawn from their whole range.
  function automatic fb_command_t random_cmd();
    fb_command_t cmd;
    int pick;
    pick = int'($urandom_range(99));
    if (pick < 45) begin
      cmd = make_cmd(OP_READ, int'($urandom_range(PANEL_WIDTH + 1)) - 2,
                     int'($urandom_range(PANEL_HEIGHT + 1)) - 2,
                     $urandom, $urandom, $urandom);
      if ($urandom_range(99) < 15) cmd.x_pos = 16'($urandom);
      if ($urandom_range(99) < 15) cmd.y_pos = 16'($urandom);
    end else begin
      cmd = make_cmd(OP_FILL, int'($urandom_range(82)) - 12, int'($urandom_range(52)) - 12,
                     int'($urandom_range(17)) - 3, int'($urandom_range(13)) - 3, $urandom);
      case ($urandom_range(19))
        0: cmd.x_pos = 16'($urandom);
        1: cmd.y_pos = 16'($urandom);
        2: cmd.rect_width = 16'($urandom);
        3: cmd.rect_height = 16'($urandom);
        4: begin
          cmd.rect_width  = 16'($urandom_range(PANEL_WIDTH + 10, 1));
          cmd.rect_height = 16'($urandom_range(PANEL_HEIGHT + 10, 1));
        end
        default: ;
      endcase
    end
    return cmd;
  endfunction

  task automatic test_random_traffic();
    int phase, n;
    int idle_by_phase [4];
    int stall_by_phase [4];
    idle_by_phase  = '{0, 80, 0, 32};
    stall_by_phase = '{0, 0, 80, 32};
    for (phase = 0; phase < 4; phase++) begin
      sender_idle_pct    = idle_by_phase[phase];
      receiver_stall_pct = stall_by_phase[phase];
      for (n = 0; n < 140; n++) send_cmd(random_cmd());
      // The sender holds off here until every answer is back.
      wait_drained();
    end
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
  endtask

  initial begin
    int i;
    for (i = 0; i < PIXELS; i++) panel_pixels[i] = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_cleared_panel();
    test_fill_shapes();
    test_empty_and_offpanel_fills();
    test_clipping();
    test_offpanel_reads();
    wait_drained();
    test_random_traffic();
    wait_drained();
    if (mismatch_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

/* sim.f */
src/fbfill_pkg.sv
src/fbfill_ram.sv
src/fbfill_front.sv
src/fbfill_queue.sv
src/fbfill_back.sv
src/framebuffer_clipped_rect_fill.sv
sim/tb_top.sv
